### rtl/crc32_name_directory_lookup_top_macros.svh
// Assertion macros shared by the directory lookup RTL.
`ifndef CRC32_NAME_DIRECTORY_LOOKUP_TOP_MACROS_SVH
`define CRC32_NAME_DIRECTORY_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define CNDL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cndl: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define CNDL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cndl: next-cycle check failed");

`endif

### rtl/cndl_pkg.sv
// Types, constants and codes for the CRC-32 name directory lookup.
package cndl_pkg;

	// Directory geometry
	localparam int MAX_ENTRIES = 256;
	localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
	localparam int COUNT_W     = 9;

	// CRC-32 (reflected)
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	// Shift counter start value, counted down to zero after the load shift
	localparam logic [2:0]  CRC_LAST_STEP = 3'd6;

	// Request opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_NAME = 1'b1;

	// Register select (paddr bit 2)
	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic REG_BASE_OFFSET = 1'b1;
	localparam int   PADDR_W         = 3;

	// One directory entry as stored in the table memory
	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] offset;
		logic [31:0] size;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CRC,
		S_READ,
		S_CMP,
		S_PUSH
	} state_t;

	// Controls for the bit-serial CRC unit
	typedef struct packed {
		logic init;
		logic load;
		logic step;
	} crc_ctrl_t;

endpackage

### rtl/cndl_if.sv
// Request and response channel interfaces of the directory lookup.
interface cndl_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  entry_index;
	logic [31:0] entry_hash;
	logic [31:0] entry_offset;
	logic [31:0] entry_size;
	logic [7:0]  name_byte;

	modport source (
		output valid, op, entry_index, entry_hash, entry_offset, entry_size, name_byte,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_hash, entry_offset, entry_size, name_byte,
		output ready
	);
endinterface

interface cndl_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] file_offset;
	logic [31:0] file_size;

	modport source (
		output valid, found, file_offset, file_size,
		input  ready
	);
	modport sink (
		input  valid, found, file_offset, file_size,
		output ready
	);
endinterface

### rtl/cndl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cndl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/cndl_crc.sv
// Bit-serial reflected CRC-32 register: one step per load or step cycle.
module cndl_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  cndl_pkg::crc_ctrl_t ctrl,
	input  logic [7:0]          data_byte,
	output logic [31:0]         crc
);

	logic [31:0] crc_q;
	logic [31:0] src;
	logic [31:0] stepped;

	// Fold in the byte on load, then shift one bit and apply the polynomial
	always_comb begin
		src     = ctrl.load ? (crc_q ^ {24'b0, data_byte}) : crc_q;
		stepped = src[0] ? ((src >> 1) ^ cndl_pkg::CRC_POLY) : (src >> 1);
	end

	// Hold, restart or advance the running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= cndl_pkg::CRC_INIT;
		end else if (ctrl.init) begin
			crc_q <= cndl_pkg::CRC_INIT;
		end else if (ctrl.load || ctrl.step) begin
			crc_q <= stepped;
		end
	end

	assign crc = crc_q;

endmodule

### rtl/crc32_name_directory_lookup_top.sv
// Top level of the CRC-32 hashed name directory lookup.
//
// Requests arrive on req (valid/ready). A load request (op 0) writes one
// directory entry (hash, offset, size) into the table RAM in its accept cycle.
// A name request (op 1) carries one file name byte: a nonzero byte is folded
// into the running CRC-32 one bit per cycle, and the block takes no new request
// until the whole byte is in; the bit-serial CRC register sets that. A zero byte
// ends the name: the inverted CRC is searched against entries 0 to
// entry_count-1 (at most 256), each entry read from the RAM read port and then
// checked by one comparator, and the first match wins; the response is then
// pushed into the output register that drives rsp once that register is free.
// The response carries found, the entry offset plus base_offset and the
// entry size; a miss returns zeros. Load and nonzero name requests give no
// response. The response sits in an output register: while rsp stalls the
// block still accepts requests, and a later lookup waits only to hand over
// its own response. Reset clears the configuration and the CRC to all ones;
// table entries are undefined until loaded. Registers sit on the APB port:
// entry_count at 0x0, base_offset at 0x4.
module crc32_name_directory_lookup_top (
	input  logic                           clk,
	input  logic                           arst_n,
	cndl_req_if.sink                       req,
	cndl_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cndl_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	cndl_pkg::state_t                     state_q;
	cndl_pkg::state_t                     state_d;
	cndl_pkg::crc_ctrl_t                  crc_ctrl;
	cndl_pkg::entry_t                     wr_entry;
	cndl_pkg::entry_t                     rd_entry;
	logic [cndl_pkg::ENTRY_W-1:0]         ram_rdata;
	logic [31:0]                          crc;
	logic [cndl_pkg::COUNT_W-1:0]         entry_count_q;
	logic [31:0]                          base_offset_q;
	logic [cndl_pkg::COUNT_W-1:0]         limit;
	logic [cndl_pkg::COUNT_W-1:0]         idx_q;
	logic [cndl_pkg::COUNT_W-1:0]         idx_next;
	logic [2:0]                           bit_q;
	logic [31:0]                          hash_q;
	logic                                 res_found_q;
	logic [31:0]                          res_offset_q;
	logic [31:0]                          res_size_q;
	logic                                 out_valid_q;
	logic                                 out_found_q;
	logic [31:0]                          out_offset_q;
	logic [31:0]                          out_size_q;
	logic                                 accept;
	logic                                 cfg_write;
	logic                                 is_load;
	logic                                 is_end;
	logic                                 ram_we;
	logic                                 ram_re;
	logic                                 hit;
	logic                                 last;
	logic                                 out_free;
	logic                                 push;

	// Request decode
	assign accept  = req.valid && req.ready;
	assign is_load = (req.op == cndl_pkg::OP_LOAD);
	assign is_end  = (req.op == cndl_pkg::OP_NAME) && (req.name_byte == 8'd0);

	// Search bound, clipped to the table depth
	assign limit = (entry_count_q > cndl_pkg::COUNT_W'(cndl_pkg::MAX_ENTRIES))
		? cndl_pkg::COUNT_W'(cndl_pkg::MAX_ENTRIES) : entry_count_q;

	// Scan compare on the registered table read
	assign rd_entry = cndl_pkg::entry_t'(ram_rdata);
	assign idx_next = idx_q + 1'b1;
	assign hit      = (rd_entry.hash == hash_q);
	assign last     = (idx_next == limit);
	assign out_free = !out_valid_q || rsp.ready;

	// APB register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == cndl_pkg::REG_BASE_OFFSET)
		? base_offset_q : {{(32 - cndl_pkg::COUNT_W){1'b0}}, entry_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			base_offset_q <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				cndl_pkg::REG_ENTRY_COUNT: entry_count_q <= pwdata[cndl_pkg::COUNT_W-1:0];
				cndl_pkg::REG_BASE_OFFSET: base_offset_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Directory table: every entry index fits the table, so loads always write
	assign wr_entry = '{hash: req.entry_hash, offset: req.entry_offset, size: req.entry_size};

	cndl_ram #(
		.WIDTH (cndl_pkg::ENTRY_W),
		.DEPTH (cndl_pkg::MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.entry_index[cndl_pkg::ENTRY_AW-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (idx_q[cndl_pkg::ENTRY_AW-1:0]),
		.rdata (ram_rdata)
	);

	// Shared bit-serial CRC unit
	cndl_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (crc_ctrl),
		.data_byte (req.name_byte),
		.crc       (crc)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cndl_pkg::S_IDLE: begin
				if (accept && !is_load) begin
					if (!is_end) begin
						state_d = cndl_pkg::S_CRC;
					end else if (limit == '0) begin
						state_d = cndl_pkg::S_PUSH;
					end else begin
						state_d = cndl_pkg::S_READ;
					end
				end
			end
			cndl_pkg::S_CRC: begin
				if (bit_q == 3'd0) begin
					state_d = cndl_pkg::S_IDLE;
				end
			end
			cndl_pkg::S_READ: begin
				state_d = cndl_pkg::S_CMP;
			end
			cndl_pkg::S_CMP: begin
				state_d = (hit || last) ? cndl_pkg::S_PUSH : cndl_pkg::S_READ;
			end
			cndl_pkg::S_PUSH: begin
				if (out_free) begin
					state_d = cndl_pkg::S_IDLE;
				end
			end
			default: state_d = cndl_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		push      = 1'b0;
		crc_ctrl  = '0;
		unique case (state_q)
			cndl_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (is_load) begin
						ram_we = 1'b1;
					end else if (is_end) begin
						crc_ctrl.init = 1'b1;
					end else begin
						crc_ctrl.load = 1'b1;
					end
				end
			end
			cndl_pkg::S_CRC: begin
				crc_ctrl.step = 1'b1;
			end
			cndl_pkg::S_READ: begin
				ram_re = 1'b1;
			end
			cndl_pkg::S_CMP: ;
			cndl_pkg::S_PUSH: begin
				push = out_free;
			end
			default: ;
		endcase
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cndl_pkg::S_IDLE;
			bit_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !is_load && !is_end) begin
				bit_q <= cndl_pkg::CRC_LAST_STEP;
			end else if (state_q == cndl_pkg::S_CRC) begin
				bit_q <= bit_q - 1'b1;
			end
			if (accept && is_end) begin
				idx_q <= '0;
			end else if (state_q == cndl_pkg::S_CMP) begin
				idx_q <= idx_next;
			end
		end
	end

	// Capture the hash at end of name and the scan result
	always_ff @(posedge clk) begin
		if (accept && is_end) begin
			hash_q       <= ~crc;
			res_found_q  <= 1'b0;
			res_offset_q <= '0;
			res_size_q   <= '0;
		end else if (state_q == cndl_pkg::S_CMP && hit) begin
			res_found_q  <= 1'b1;
			res_offset_q <= rd_entry.offset + base_offset_q;
			res_size_q   <= rd_entry.size;
		end
	end

	// Output register: fill on push, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_found_q  <= res_found_q;
			out_offset_q <= res_offset_q;
			out_size_q   <= res_size_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.file_offset = out_offset_q;
	assign rsp.file_size   = out_size_q;

`include "crc32_name_directory_lookup_top_macros.svh"

	// A compare always follows the read that fetched its entry
	`CNDL_ASSERT_NOW(a_cmp_after_read, state_q == cndl_pkg::S_CMP,
		$past(state_q) == cndl_pkg::S_READ)
	// The scan never reads past the search bound
	`CNDL_ASSERT_NOW(a_scan_in_bound, state_q == cndl_pkg::S_READ, idx_q < limit)
	// End of name restarts the CRC
	`CNDL_ASSERT_NEXT(a_crc_restart, accept && is_end, crc == cndl_pkg::CRC_INIT)
	// A miss carries zero offset and size
	`CNDL_ASSERT_NOW(a_miss_zero, out_valid_q && !out_found_q,
		out_offset_q == 32'd0 && out_size_q == 32'd0)

endmodule
